// ===== rtl/wcct_pkg.sv =====
package wcct_pkg;

  localparam int ENTRIES = 256;
  localparam int CHUNKS  = 8;

  localparam int ENTRY_W = 8;
  localparam int OFF_W   = 32;
  localparam int LEN_W   = 16;
  localparam int CNT_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int KIND_W  = 3;

  localparam int CHUNK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int IDX_W      = $clog2(CHUNKS + 1);
  localparam int SLOT_DEPTH = ENTRIES * CHUNKS;
  localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int HDR_AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    RK_HDR   = 3'd0,
    RK_HIT   = 3'd1,
    RK_NEW   = 3'd2,
    RK_EVICT = 3'd3,
    RK_FLUSH = 3'd4,
    RK_IDLE  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic [CNT_W-1:0] cnt;
  } slot_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [CNT_W-1:0] cnt;
  } hdr_word_t;

  typedef struct packed {
    logic             match;
    logic             free;
    logic             dirty;
    logic [CNT_W-1:0] cnt_inc;
  } slot_eval_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic              last;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/write_combining_chunk_table.sv =====
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | opcode, entry_index, write_offset_in, write_length_in
// out_    | output    | out_valid/out_stall| result_kind, slot, out_offset, out_length, last
//
// Header write: header read, then result and header update. Chunk write: one slot compare
// per cycle through the shared slot evaluator over the single slot RAM read port, until a
// match or the last slot, then the result. Flush: a scan of all slots, then the header (or
// idle) result, then each dirty slot. After reset a clearing pass zeroes both tables; in_stall
// is high meanwhile. A stalled out_ holds its transaction; the sequencer waits on it.
module write_combining_chunk_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [wcct_pkg::ENTRY_W-1:0]  in_entry_index,
  input  logic [wcct_pkg::OFF_W-1:0]    in_write_offset_in,
  input  logic [wcct_pkg::LEN_W-1:0]    in_write_length_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wcct_pkg::KIND_W-1:0]   out_result_kind,
  output logic [wcct_pkg::SLOT_W-1:0]   out_slot,
  output logic [wcct_pkg::OFF_W-1:0]    out_out_offset,
  output logic [wcct_pkg::LEN_W-1:0]    out_out_length,
  output logic                          out_last
);
  import wcct_pkg::*;

  logic   busy;
  logic   res_valid;
  logic   res_ready;
  res_t   res;
  logic   out_valid_r;
  res_t   out_res_r;

  wcct_seq u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_opcode          (in_opcode),
    .in_entry_index     (in_entry_index),
    .in_write_offset_in (in_write_offset_in),
    .in_write_length_in (in_write_length_in),
    .busy               (busy),
    .res_valid          (res_valid),
    .res                (res),
    .res_ready          (res_ready)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign in_stall        = busy;
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_res_r.kind;
  assign out_slot        = out_res_r.slot;
  assign out_out_offset  = out_res_r.offset;
  assign out_out_length  = out_res_r.length;
  assign out_last        = out_res_r.last;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while sequencer stays idle");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == RK_HDR || out_result_kind == RK_HIT ||
                   out_result_kind == RK_NEW || out_result_kind == RK_IDLE))
    |-> (out_out_offset == '0 && out_out_length == '0))
    else $error("non-writeback result carries offset or length");

  a_multi_is_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_result_kind == RK_FLUSH))
    else $error("non-final result outside a flush");

  a_header_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == RK_HDR || out_result_kind == RK_IDLE))
    |-> (out_slot == SLOT_W'(CHUNKS)))
    else $error("header result with chunk slot");

endmodule

// ===== rtl/wcct_slot_eval.sv =====
module wcct_slot_eval (
  input  wcct_pkg::slot_word_t     word,
  input  logic [wcct_pkg::OFF_W-1:0] off,
  output wcct_pkg::slot_eval_t     ev
);
  import wcct_pkg::*;

  always_comb begin
    ev.match   = (word.offset == off);
    ev.free    = (word.offset == '0) || (word.cnt == '0);
    ev.dirty   = (word.cnt != '0);
    ev.cnt_inc = sat_inc(word.cnt);
  end

endmodule

// ===== rtl/wcct_seq.sv =====
module wcct_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_opcode,
  input  logic [wcct_pkg::ENTRY_W-1:0]  in_entry_index,
  input  logic [wcct_pkg::OFF_W-1:0]    in_write_offset_in,
  input  logic [wcct_pkg::LEN_W-1:0]    in_write_length_in,
  output logic                          busy,
  output logic                          res_valid,
  output wcct_pkg::res_t                res,
  input  logic                          res_ready
);
  import wcct_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_HRD   = 10'b00_0000_0100,
    S_HWR   = 10'b00_0000_1000,
    S_SCAN  = 10'b00_0001_0000,
    S_HIT   = 10'b00_0010_0000,
    S_PLACE = 10'b00_0100_0000,
    S_FHDR  = 10'b00_1000_0000,
    S_FWALK = 10'b01_0000_0000,
    S_FEMIT = 10'b10_0000_0000
  } state_t;

  slot_word_t slot_mem [SLOT_DEPTH];
  hdr_word_t  hdr_mem  [ENTRIES];

  state_t               state_r, state_nxt;
  logic [SLOT_AW-1:0]   clr_r, clr_nxt;
  logic                 op_r, op_nxt;
  logic [ENTRY_W-1:0]   entry_r, entry_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CHUNK_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic                 found_free_r, found_free_nxt;
  logic [CHUNK_W-1:0]   free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]     free_cnt_r, free_cnt_nxt;
  logic [OFF_W-1:0]     s0_off_r, s0_off_nxt;
  logic [LEN_W-1:0]     s0_len_r, s0_len_nxt;
  logic                 any_r, any_nxt;
  logic [CHUNK_W-1:0]   last_slot_r, last_slot_nxt;

  slot_word_t           slot_q;
  hdr_word_t            hdr_q;
  slot_eval_t           ev;

  logic                 slot_re;
  logic [CHUNK_W-1:0]   slot_ra_idx;
  logic                 slot_we;
  logic [SLOT_AW-1:0]   slot_wa;
  logic [CHUNK_W-1:0]   slot_wa_idx;
  slot_word_t           slot_wd;
  logic                 hdr_we;
  logic [HDR_AW-1:0]    hdr_wa;
  hdr_word_t            hdr_wd;

  logic                 accept;
  logic                 issue;
  logic                 scan_last;
  logic                 pend;
  logic [HDR_AW-1:0]    hdr_ra;

  function automatic logic [SLOT_AW-1:0] slot_addr(input logic [ENTRY_W-1:0] e,
                                                   input logic [CHUNK_W-1:0] i);
    logic [SLOT_AW-1:0] a;
    a = SLOT_AW'(int'(e) * CHUNKS + int'(i));
    return a;
  endfunction

  wcct_slot_eval u_eval (
    .word (slot_q),
    .off  (off_r),
    .ev   (ev)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign issue     = (idx_r < IDX_W'(CHUNKS));
  assign scan_last = (rd_idx_r == CHUNK_W'(CHUNKS - 1));
  assign pend      = any_r || (hdr_q.cnt != '0);
  assign hdr_ra    = HDR_AW'(entry_r);

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (slot_re) begin
      slot_q <= slot_mem[slot_addr(entry_r, slot_ra_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[hdr_wa] <= hdr_wd;
    end
    hdr_q <= hdr_mem[hdr_ra];
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    entry_nxt      = entry_r;
    off_nxt        = off_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    rd_idx_nxt     = rd_idx_r;
    rd_vld_nxt     = rd_vld_r;
    found_free_nxt = found_free_r;
    free_idx_nxt   = free_idx_r;
    free_cnt_nxt   = free_cnt_r;
    s0_off_nxt     = s0_off_r;
    s0_len_nxt     = s0_len_r;
    any_nxt        = any_r;
    last_slot_nxt  = last_slot_r;

    slot_re     = 1'b0;
    slot_ra_idx = idx_r[CHUNK_W-1:0];
    slot_we     = 1'b0;
    slot_wa_idx = rd_idx_r;
    slot_wa     = slot_addr(entry_r, slot_wa_idx);
    slot_wd     = '0;
    hdr_we      = 1'b0;
    hdr_wa      = hdr_ra;
    hdr_wd      = '0;

    res_valid   = 1'b0;
    res.kind    = RK_HDR;
    res.slot    = SLOT_W'(CHUNKS);
    res.offset  = '0;
    res.length  = '0;
    res.last    = 1'b1;

    case (state_r)
      S_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr_r;
        hdr_we  = ({1'b0, clr_r} < (SLOT_AW + 1)'(ENTRIES));
        hdr_wa  = HDR_AW'(clr_r);
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SLOT_AW'(SLOT_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && (int'(in_entry_index) < ENTRIES)) begin
          op_nxt         = in_opcode;
          entry_nxt      = in_entry_index;
          off_nxt        = in_write_offset_in;
          len_nxt        = in_write_length_in;
          idx_nxt        = '0;
          rd_vld_nxt     = 1'b0;
          found_free_nxt = 1'b0;
          any_nxt        = 1'b0;
          if (in_opcode == OP_WRITE && in_write_offset_in == '0) begin
            state_nxt = S_HRD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_HRD: begin
        state_nxt = S_HWR;
      end
      S_HWR: begin
        res_valid = 1'b1;
        res.kind  = RK_HDR;
        if (res_ready) begin
          hdr_we    = 1'b1;
          hdr_wd    = '{length: len_r, cnt: sat_inc(hdr_q.cnt)};
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        slot_re = issue && !(rd_vld_r && op_r == OP_WRITE && ev.match);
        if (slot_re) begin
          idx_nxt    = idx_r + 1'b1;
          rd_idx_nxt = idx_r[CHUNK_W-1:0];
          rd_vld_nxt = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
        end
        if (rd_vld_r) begin
          if (op_r == OP_WRITE) begin
            if (rd_idx_r == '0) begin
              s0_off_nxt = slot_q.offset;
              s0_len_nxt = slot_q.length;
            end
            if (!found_free_r && ev.free) begin
              found_free_nxt = 1'b1;
              free_idx_nxt   = rd_idx_r;
              free_cnt_nxt   = slot_q.cnt;
            end
            if (ev.match) begin
              state_nxt = S_HIT;
            end else if (scan_last) begin
              state_nxt = S_PLACE;
            end
          end else begin
            if (ev.dirty) begin
              any_nxt       = 1'b1;
              last_slot_nxt = rd_idx_r;
            end
            if (scan_last) begin
              state_nxt = S_FHDR;
            end
          end
        end
      end
      S_HIT: begin
        res_valid = 1'b1;
        res.kind  = RK_HIT;
        res.slot  = SLOT_W'(rd_idx_r);
        if (res_ready) begin
          slot_we   = 1'b1;
          slot_wd   = '{offset: off_r, length: len_r, cnt: ev.cnt_inc};
          state_nxt = S_IDLE;
        end
      end
      S_PLACE: begin
        res_valid = 1'b1;
        if (found_free_r) begin
          res.kind    = RK_NEW;
          res.slot    = SLOT_W'(free_idx_r);
          slot_wa_idx = free_idx_r;
          slot_wd     = '{offset: off_r, length: len_r, cnt: sat_inc(free_cnt_r)};
        end else begin
          res.kind    = RK_EVICT;
          res.slot    = '0;
          res.offset  = s0_off_r;
          res.length  = s0_len_r;
          slot_wa_idx = '0;
          slot_wd     = '{offset: off_r, length: len_r, cnt: CNT_W'(1)};
        end
        slot_wa = slot_addr(entry_r, slot_wa_idx);
        if (res_ready) begin
          slot_we   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FHDR: begin
        res_valid = 1'b1;
        if (!pend) begin
          res.kind = RK_IDLE;
          if (res_ready) begin
            state_nxt = S_IDLE;
          end
        end else begin
          res.kind   = RK_FLUSH;
          res.length = hdr_q.length;
          res.last   = !any_r;
          if (res_ready) begin
            hdr_we  = 1'b1;
            hdr_wd  = '{length: hdr_q.length, cnt: '0};
            idx_nxt = '0;
            state_nxt = any_r ? S_FWALK : S_IDLE;
          end
        end
      end
      S_FWALK: begin
        slot_re    = 1'b1;
        rd_idx_nxt = idx_r[CHUNK_W-1:0];
        state_nxt  = S_FEMIT;
      end
      S_FEMIT: begin
        if (!ev.dirty) begin
          idx_nxt   = IDX_W'(rd_idx_r) + 1'b1;
          state_nxt = S_FWALK;
        end else begin
          res_valid  = 1'b1;
          res.kind   = RK_FLUSH;
          res.slot   = SLOT_W'(rd_idx_r);
          res.offset = slot_q.offset;
          res.length = slot_q.length;
          res.last   = (rd_idx_r == last_slot_r);
          if (res_ready) begin
            slot_we = 1'b1;
            slot_wd = '{offset: slot_q.offset, length: slot_q.length, cnt: '0};
            idx_nxt = IDX_W'(rd_idx_r) + 1'b1;
            state_nxt = (rd_idx_r == last_slot_r) ? S_IDLE : S_FWALK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    entry_r      <= entry_nxt;
    off_r        <= off_nxt;
    len_r        <= len_nxt;
    idx_r        <= idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    rd_vld_r     <= rd_vld_nxt;
    found_free_r <= found_free_nxt;
    free_idx_r   <= free_idx_nxt;
    free_cnt_r   <= free_cnt_nxt;
    s0_off_r     <= s0_off_nxt;
    s0_len_r     <= s0_len_nxt;
    any_r        <= any_nxt;
    last_slot_r  <= last_slot_nxt;
  end

endmodule

// ===== tb/chunk_table_checker.sv =====
`timescale 1ns / 1ps

module chunk_table_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [wcct_pkg::ENTRY_W-1:0] in_entry_index,
  input  logic [wcct_pkg::OFF_W-1:0]   in_write_offset_in,
  input  logic [wcct_pkg::LEN_W-1:0]   in_write_length_in,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [wcct_pkg::KIND_W-1:0]  out_result_kind,
  input  logic [wcct_pkg::SLOT_W-1:0]  out_slot,
  input  logic [wcct_pkg::OFF_W-1:0]   out_out_offset,
  input  logic [wcct_pkg::LEN_W-1:0]   out_out_length,
  input  logic                         out_last,
  output int                           fail_count,
  output int                           pending_results,
  output int                           txn_in,
  output int                           txn_out,
  output int                           hits_seen,
  output int                           evictions_seen
);
  import wcct_pkg::*;

  logic [OFF_W-1:0] chunk_off [SLOT_DEPTH];
  logic [LEN_W-1:0] chunk_len [SLOT_DEPTH];
  logic [CNT_W-1:0] chunk_cnt [SLOT_DEPTH];
  logic [LEN_W-1:0] hdr_len   [ENTRIES];
  logic [CNT_W-1:0] hdr_cnt   [ENTRIES];

  res_t due_results [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
    txn_in          = 0;
    txn_out         = 0;
    hits_seen       = 0;
    evictions_seen  = 0;
  end

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic add_due(input kind_t k, input int s, input logic [OFF_W-1:0] o,
                         input logic [LEN_W-1:0] l, input bit lst);
    res_t r;
    r.kind   = k;
    r.slot   = SLOT_W'(s);
    r.offset = o;
    r.length = l;
    r.last   = lst;
    due_results.push_back(r);
  endtask

  task automatic predict_chunk_txn(input opcode_t op, input logic [ENTRY_W-1:0] ent,
                                   input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len);
    int  base;
    int  i;
    int  free_slot;
    int  last_dirty;
    bit  done;
    bit  busy;
    base       = int'(ent) * CHUNKS;
    free_slot  = -1;
    last_dirty = -1;
    done       = 1'b0;
    if (op == OP_WRITE) begin
      if (off == '0) begin
        hdr_len[ent] = len;
        hdr_cnt[ent] = count_up(hdr_cnt[ent]);
        add_due(RK_HDR, CHUNKS, '0, '0, 1'b1);
      end else begin
        for (i = 0; i < CHUNKS && !done; i++) begin
          if (chunk_off[base+i] == off) begin
            chunk_len[base+i] = len;
            chunk_cnt[base+i] = count_up(chunk_cnt[base+i]);
            add_due(RK_HIT, i, '0, '0, 1'b1);
            done = 1'b1;
          end else if (free_slot < 0 && (chunk_off[base+i] == '0 || chunk_cnt[base+i] == '0)) begin
            free_slot = i;
          end
        end
        if (!done && free_slot >= 0) begin
          chunk_off[base+free_slot] = off;
          chunk_len[base+free_slot] = len;
          chunk_cnt[base+free_slot] = count_up(chunk_cnt[base+free_slot]);
          add_due(RK_NEW, free_slot, '0, '0, 1'b1);
        end else if (!done) begin
          add_due(RK_EVICT, 0, chunk_off[base], chunk_len[base], 1'b1);
          chunk_off[base] = off;
          chunk_len[base] = len;
          chunk_cnt[base] = CNT_W'(1);
        end
      end
    end else begin
      busy = (hdr_cnt[ent] != '0);
      for (i = 0; i < CHUNKS; i++) begin
        if (chunk_cnt[base+i] != '0) begin
          busy       = 1'b1;
          last_dirty = i;
        end
      end
      if (!busy) begin
        add_due(RK_IDLE, CHUNKS, '0, '0, 1'b1);
      end else begin
        add_due(RK_FLUSH, CHUNKS, '0, hdr_len[ent], last_dirty < 0);
        for (i = 0; i < CHUNKS; i++) begin
          if (chunk_cnt[base+i] != '0) begin
            add_due(RK_FLUSH, i, chunk_off[base+i], chunk_len[base+i], i == last_dirty);
            chunk_cnt[base+i] = '0;
          end
        end
        hdr_cnt[ent] = '0;
      end
    end
  endtask

  task automatic check_result();
    res_t want;
    txn_out++;
    if (due_results.size() == 0) begin
      report_mismatch("result with nothing due, result_kind", out_result_kind, 0);
      return;
    end
    want = due_results.pop_front();
    if (want.kind == RK_EVICT) evictions_seen++;
    if (want.kind == RK_HIT) hits_seen++;
    if (out_result_kind != want.kind) report_mismatch("result_kind", out_result_kind, want.kind);
    if (out_slot != want.slot) report_mismatch("slot", out_slot, want.slot);
    if (out_out_offset != want.offset) report_mismatch("out_offset", out_out_offset, want.offset);
    if (out_out_length != want.length) report_mismatch("out_length", out_out_length, want.length);
    if (out_last != want.last) report_mismatch("last", out_last, want.last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_DEPTH; i++) begin
        chunk_off[i] = '0;
        chunk_len[i] = '0;
        chunk_cnt[i] = '0;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        hdr_len[i] = '0;
        hdr_cnt[i] = '0;
      end
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        txn_in++;
        predict_chunk_txn(opcode_t'(in_opcode), in_entry_index, in_write_offset_in,
                          in_write_length_in);
      end
    end
    pending_results = due_results.size();
  end

endmodule

// ===== tb/write_combining_chunk_table_tb.sv =====
`timescale 1ns / 1ps

module write_combining_chunk_table_tb;
  import wcct_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_opcode;
  logic [ENTRY_W-1:0] in_entry_index;
  logic [OFF_W-1:0]   in_write_offset_in;
  logic [LEN_W-1:0]   in_write_length_in;
  logic               out_valid;
  logic               out_stall;
  logic [KIND_W-1:0]  out_result_kind;
  logic [SLOT_W-1:0]  out_slot;
  logic [OFF_W-1:0]   out_out_offset;
  logic [LEN_W-1:0]   out_out_length;
  logic               out_last;

  int fail_count;
  int pending_results;
  int txn_in;
  int txn_out;
  int hits_seen;
  int evictions_seen;

  int burst_left = 0;

  logic [OFF_W-1:0]   off_pool  [12];
  logic [ENTRY_W-1:0] hot_entry [3];

  always #5 clk = ~clk;

  write_combining_chunk_table i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_entry_index     (in_entry_index),
    .in_write_offset_in (in_write_offset_in),
    .in_write_length_in (in_write_length_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_slot           (out_slot),
    .out_out_offset     (out_out_offset),
    .out_out_length     (out_out_length),
    .out_last           (out_last)
  );

  chunk_table_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_entry_index     (in_entry_index),
    .in_write_offset_in (in_write_offset_in),
    .in_write_length_in (in_write_length_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_slot           (out_slot),
    .out_out_offset     (out_out_offset),
    .out_out_length     (out_out_length),
    .out_last           (out_last),
    .fail_count         (fail_count),
    .pending_results    (pending_results),
    .txn_in             (txn_in),
    .txn_out            (txn_out),
    .hits_seen          (hits_seen),
    .evictions_seen     (evictions_seen)
  );

  // receiver back-pressure in one of four patterns, chosen anew at random
  initial begin
    int mode;
    int span;
    int k;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 3) != 0);
          default: out_stall = k[2];
        endcase
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("[write_combining_chunk_table] ERROR");
    $finish;
  end

  task automatic send_txn(input opcode_t op, input logic [ENTRY_W-1:0] ent,
                          input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len);
    in_valid           = 1'b1;
    in_opcode          = op;
    in_entry_index     = ent;
    in_write_offset_in = off;
    in_write_length_in = len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pace(input bit gapless);
    if (gapless) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic random_txn(input int flush_pct);
    opcode_t            op;
    logic [ENTRY_W-1:0] ent;
    logic [OFF_W-1:0]   off;
    logic [LEN_W-1:0]   len;
    int                 r;
    op  = ($urandom_range(0, 99) < flush_pct) ? OP_FLUSH : OP_WRITE;
    ent = ($urandom_range(0, 99) < 85) ? hot_entry[$urandom_range(0, 2)]
                                       : ENTRY_W'($urandom_range(0, ENTRIES - 1));
    r = $urandom_range(0, 99);
    if (r < 15) off = '0;
    else if (r < 85) off = off_pool[$urandom_range(0, 11)];
    else off = $urandom;
    r = $urandom_range(0, 99);
    if (r < 10) len = '0;
    else if (r < 20) len = '1;
    else len = LEN_W'($urandom_range(0, 65535));
    send_txn(op, ent, off, len);
  endtask

  initial begin
    int  n;
    int  flush_pct;
    bit  gapless;
    in_valid           = 1'b0;
    in_opcode          = OP_WRITE;
    in_entry_index     = '0;
    in_write_offset_in = '0;
    in_write_length_in = '0;
    rst_n              = 1'b0;

    off_pool[0] = 32'h1;
    off_pool[1] = 32'hFFFF_FFFF;
    for (n = 2; n < 12; n++) begin
      off_pool[n] = $urandom;
      if (off_pool[n] == '0) off_pool[n] = 32'h8000_0000;
    end
    hot_entry[0] = '0;
    hot_entry[1] = '1;
    hot_entry[2] = ENTRY_W'($urandom_range(1, ENTRIES - 2));

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: idle flush, header only, hit, fill and evict, full flush
    send_txn(OP_FLUSH, 8'd0, 32'h0, 16'h0);
    send_txn(OP_WRITE, 8'd0, 32'h0, 16'hFFFF);
    send_txn(OP_FLUSH, 8'd0, 32'h0, 16'h0);
    send_txn(OP_WRITE, 8'd255, 32'hFFFF_FFFF, 16'h0);
    pace(1'b0);
    send_txn(OP_WRITE, 8'd255, 32'hFFFF_FFFF, 16'hFFFF);
    send_txn(OP_FLUSH, 8'd255, 32'h0, 16'h0);
    for (n = 1; n <= CHUNKS; n++) begin
      send_txn(OP_WRITE, 8'd1, OFF_W'(n), LEN_W'(n * 16'h1111));
      pace(1'b0);
    end
    send_txn(OP_WRITE, 8'd1, 32'd9, 16'hA5A5);
    send_txn(OP_WRITE, 8'd1, 32'd2, 16'h5A5A);
    send_txn(OP_FLUSH, 8'd1, 32'h0, 16'h0);
    send_txn(OP_WRITE, 8'd1, 32'd100, 16'h0001);
    send_txn(OP_FLUSH, 8'd1, 32'h0, 16'h0);
    send_txn(OP_FLUSH, 8'd1, 32'h0, 16'h0);

    flush_pct = 10;
    gapless   = 1'b0;
    for (n = 0; n < 430; n++) begin
      if (n % 75 == 0) begin
        case ($urandom_range(0, 2))
          0: flush_pct = 3;
          1: flush_pct = 10;
          default: flush_pct = 25;
        endcase
        gapless = ($urandom_range(0, 3) == 0);
      end
      random_txn(flush_pct);
      pace(gapless);
    end
    in_valid = 1'b0;

    while (pending_results != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("run covered %0d input transactions and %0d results", txn_in, txn_out);
    $display("including %0d chunk hits and %0d slot 0 evictions", hits_seen, evictions_seen);
    if (fail_count == 0 && pending_results == 0) begin
      $display("[write_combining_chunk_table] OK");
    end else begin
      $display("[write_combining_chunk_table] ERROR");
    end
    $finish;
  end

endmodule
